// ===== hdl/obstacle_map_rasterizer_macros.svh =====
// assertion macros used by the rasterizer top level
`ifndef OBSTACLE_MAP_RASTERIZER_MACROS_SVH
`define OBSTACLE_MAP_RASTERIZER_MACROS_SVH

// same-cycle implication on clk, quiet while in reset
`define OMR_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rasterizer check failed");

// next-cycle implication on clk, quiet while in reset
`define OMR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rasterizer check failed");

`endif

// ===== hdl/omr_pkg.sv =====
`timescale 1ns / 1ps
package omr_pkg;

	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;

	localparam logic [15:0] PPM_RESET  = 16'd5120;
	localparam logic [8:0]  ROWS_RESET = 9'd256;
	localparam logic [8:0]  COLS_RESET = 9'd256;

	localparam logic [1:0] CFG_PPM  = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_COLS = 2'd2;

	// scaled coordinate (Q.16 pixels), doubled bounds, offsets, magnitudes, squares
	localparam int PW    = 37;
	localparam int BW    = 39;
	localparam int DW    = 38;
	localparam int MW    = 37;
	localparam int SQ_LO = 19;
	localparam int SQW   = 2 * MW;
	localparam int TW    = 76;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_RECT  = 2'd1,
		MODE_DISC  = 2'd2,
		MODE_READ  = 2'd3
	} omr_mode_t;

	typedef enum logic [1:0] {
		SQ_CX  = 2'd0,
		SQ_E0  = 2'd1,
		SQ_RAD = 2'd2
	} omr_sq_sel_t;

	typedef struct packed {
		logic        load;
		logic        prep;
		logic        sq_start;
		logic        sq_capture;
		omr_sq_sel_t sq_sel;
		logic        scan;
		logic        clear;
		logic        read;
		logic        resp_load;
	} omr_cmd_t;

	typedef struct packed {
		omr_mode_t mode;
		logic      empty_area;
		logic      rad_neg;
		logic      sq_done;
		logic      scan_last;
		logic      clr_last;
	} omr_status_t;

endpackage

// ===== hdl/obstacle_map_rasterizer.sv =====
`timescale 1ns / 1ps
// one command at a time; the result beat follows the last grid cycle through ST_RESP and the output register
// clear: a sweep over every storage bit, one storage bit per cycle through the grid ram port
// rectangle: a scan over rows*cols cells, disc: the same scan after three squarings
// read cell: one grid read; empty area or negative radius: straight to the result, no scan
// arst_n clears control state, then a clearing pass over the whole storage frees the
// grid with s_tready low; configuration writes are taken throughout
module obstacle_map_rasterizer #(
	parameter int MAX_ROWS = omr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = omr_pkg::MAX_COLS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// center_x[20:0] center_y[41:21] size_x[62:42] size_y[83:63] disc_radius[104:84]
	// read_row[112:105] read_col[120:113], zero pad to 127
	input  logic [127:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_value[7:0] command_done[8], zero pad to 15
	output logic [15:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import omr_pkg::*;

	omr_cmd_t    cmd;
	omr_status_t status;
	logic [7:0]  cell_value;
	logic signed [20:0] in_cx, in_cy, in_sx, in_sy, in_rad;

	assign cfg_ready = 1'b1;

	assign in_cx  = s_tdata[20:0];
	assign in_cy  = s_tdata[41:21];
	assign in_sx  = s_tdata[62:42];
	assign in_sy  = s_tdata[83:63];
	assign in_rad = s_tdata[104:84];

	omr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	omr_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_mode     (omr_mode_t'(s_tuser)),
		.in_cx       (in_cx),
		.in_cy       (in_cy),
		.in_sx       (in_sx),
		.in_sy       (in_sy),
		.in_rad      (in_rad),
		.in_read_row (s_tdata[112:105]),
		.in_read_col (s_tdata[120:113]),
		.cell_value  (cell_value)
	);

	assign m_tdata = {7'd0, 1'b1, cell_value};

`include "obstacle_map_rasterizer_macros.svh"

	// a sweep over the grid never overlaps taking a command
	`OMR_ASSERT_NOW(a_clear_blocks_input, cmd.clear, !s_tready)
	// the grid port serves one purpose a cycle
	`OMR_ASSERT_NOW(a_grid_port_single, 1'b1, $onehot0({cmd.clear, cmd.scan, cmd.read}))
	// a loaded result is offered on the next cycle
	`OMR_ASSERT_NEXT(a_result_offered, cmd.resp_load, m_tvalid)
	// a taken command closes the input until it is done
	`OMR_ASSERT_NEXT(a_one_command, s_tvalid && s_tready, !s_tready)

endmodule

// ===== hdl/omr_ram.sv =====
`timescale 1ns / 1ps
module omr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/omr_squarer.sv =====
`timescale 1ns / 1ps
module omr_squarer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [omr_pkg::MW-1:0]  m,
	output logic                    done,
	output logic [omr_pkg::SQW-1:0] square
);
	import omr_pkg::*;

	logic              busy_q;
	logic [1:0]        cnt_q;
	logic              done_q;
	logic [MW-1:0]     m_q;
	logic [2*SQ_LO-1:0] p_q;
	logic [SQW-1:0]    acc_q;
	logic [SQ_LO-1:0]  ml;
	logic [SQ_LO-1:0]  mh;
	logic [SQ_LO-1:0]  op_a;
	logic [SQ_LO-1:0]  op_b;
	logic [2*SQ_LO-1:0] prod;

	assign ml = m_q[SQ_LO-1:0];
	assign mh = SQ_LO'(m_q[MW-1:SQ_LO]);

	// lo*lo, lo*hi, hi*hi, one partial product a cycle
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = ml;
				op_b = ml;
			end
			2'd1: begin
				op_a = ml;
				op_b = mh;
			end
			default: begin
				op_a = mh;
				op_b = mh;
			end
		endcase
		prod = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= m;
		end
		if (busy_q) begin
			p_q <= prod;
			case (cnt_q)
				2'd0: acc_q <= '0;
				2'd1: acc_q <= acc_q + SQW'(p_q);
				2'd2: acc_q <= acc_q + (SQW'(p_q) << (SQ_LO + 1));
				default: acc_q <= acc_q + (SQW'(p_q) << (2 * SQ_LO));
			endcase
		end
	end

	assign done   = done_q;
	assign square = acc_q;

endmodule

// ===== hdl/omr_ctrl.sv =====
`timescale 1ns / 1ps
module omr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  omr_pkg::omr_status_t status,
	output omr_pkg::omr_cmd_t    cmd
);
	import omr_pkg::*;

	typedef enum logic [7:0] {
		ST_INIT    = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_PREP    = 8'b0000_0100,
		ST_SQ_GO   = 8'b0000_1000,
		ST_SQ_WAIT = 8'b0001_0000,
		ST_SCAN    = 8'b0010_0000,
		ST_CLEAR   = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} omr_state_t;

	omr_state_t  state_q, state_d;
	omr_sq_sel_t sel_q, sel_d;
	logic        out_valid_q;

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.sq_sel = sel_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				unique case (status.mode)
					MODE_CLEAR: state_d = ST_CLEAR;
					MODE_RECT:  state_d = status.empty_area ? ST_RESP : ST_SCAN;
					MODE_DISC: begin
						if (status.empty_area || status.rad_neg) begin
							state_d = ST_RESP;
						end else begin
							sel_d   = SQ_CX;
							state_d = ST_SQ_GO;
						end
					end
					MODE_READ: begin
						cmd.read = 1'b1;
						state_d  = ST_RESP;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_SQ_GO: begin
				cmd.sq_start = 1'b1;
				state_d      = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (status.sq_done) begin
					cmd.sq_capture = 1'b1;
					case (sel_q)
						SQ_CX: begin
							sel_d   = SQ_E0;
							state_d = ST_SQ_GO;
						end
						SQ_E0: begin
							sel_d   = SQ_RAD;
							state_d = ST_SQ_GO;
						end
						default: state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_RESP;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// wait for the output slot to free up
				if (!out_valid_q || m_tready) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sel_q       <= SQ_CX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== hdl/omr_datapath.sv =====
`timescale 1ns / 1ps
module omr_datapath #(
	parameter int MAX_ROWS = omr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = omr_pkg::MAX_COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  omr_pkg::omr_cmd_t    cmd,
	output omr_pkg::omr_status_t status,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  omr_pkg::omr_mode_t   in_mode,
	input  logic signed [20:0]   in_cx,
	input  logic signed [20:0]   in_cy,
	input  logic signed [20:0]   in_sx,
	input  logic signed [20:0]   in_sy,
	input  logic signed [20:0]   in_rad,
	input  logic [7:0]           in_read_row,
	input  logic [7:0]           in_read_col,
	output logic [7:0]           cell_value
);
	import omr_pkg::*;

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int AW  = RW + CW;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	localparam logic signed [DW-1:0] STEP_D  = {{(DW - 17){1'b0}}, 1'b1, 16'd0};
	localparam logic signed [TW-1:0] STEP_SQ = {{(TW - 33){1'b0}}, 1'b1, 32'd0};

	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] n;
		n = -v;
		return v[DW-1] ? MW'(n) : MW'(v);
	endfunction

	// configuration
	logic [15:0] ppm_q;
	logic [8:0]  rows_cfg_q;
	logic [8:0]  cols_cfg_q;

	// command payload
	omr_mode_t          mode_q;
	logic signed [PW-1:0] cx_q, cy_q, sx_q, sy_q, rad_q;
	logic [RW-1:0]      rd_row_q;
	logic [CW-1:0]      rd_col_q;
	logic               rd_oob_q;

	// rectangle bounds, doubled
	logic signed [BW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;

	// disc offsets and running squares
	logic signed [DW-1:0] d_q, e_q;
	logic signed [TW-1:0] d2_q, cx2_q, t_q;

	// scan and sweep counters
	logic [RW-1:0]  i_q;
	logic [CW-1:0]  j_q;
	logic [RCW-1:0] y_q;
	logic [AW-1:0]  clr_addr_q;

	logic [7:0] cell_q;

	logic [RCW-1:0] rows_eff;
	logic [CCW-1:0] cols_eff;
	logic signed [16:0] ppm_s;
	logic signed [DW-1:0] prod_cx, prod_cy, prod_sx, prod_sy, prod_rad;
	logic signed [BW-1:0] cx_b, cy_b, sx_b, sy_b;
	logic signed [BW-1:0] x2, y2;
	logic rect_hit, disc_hit, hit;
	logic col_last, row_last;
	logic [MW-1:0]  sq_m;
	logic           sq_done;
	logic [SQW-1:0] sq_res;
	logic signed [TW-1:0] sq_ext;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_addr;
	logic [0:0]     mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q      <= PPM_RESET;
			rows_cfg_q <= ROWS_RESET;
			cols_cfg_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PPM:  ppm_q      <= cfg_data;
				CFG_ROWS: rows_cfg_q <= cfg_data[8:0];
				CFG_COLS: cols_cfg_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// counts above the storage saturate
	always_comb begin
		if (32'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(rows_cfg_q);
		end
		if (32'(cols_cfg_q) > MAX_COLS) begin
			cols_eff = CCW'(MAX_COLS);
		end else begin
			cols_eff = CCW'(cols_cfg_q);
		end
	end

	assign ppm_s    = $signed({1'b0, ppm_q});
	assign prod_cx  = in_cx * ppm_s;
	assign prod_cy  = in_cy * ppm_s;
	assign prod_sx  = in_sx * ppm_s;
	assign prod_sy  = in_sy * ppm_s;
	assign prod_rad = in_rad * ppm_s;

	assign cx_b = BW'(cx_q);
	assign cy_b = BW'(cy_q);
	assign sx_b = BW'(sx_q);
	assign sy_b = BW'(sy_q);

	assign x2 = $signed(BW'({j_q, 17'd0}));
	assign y2 = $signed(BW'({y_q, 17'd0}));

	assign rect_hit = (y2 >= lo_y_q) && (y2 <= hi_y_q) && (x2 >= lo_x_q) && (x2 <= hi_x_q);
	assign disc_hit = (d2_q <= t_q);
	assign hit      = (mode_q == MODE_RECT) ? rect_hit : disc_hit;

	assign col_last = (CCW'(j_q) == cols_eff - CCW'(1));
	assign row_last = (RCW'(i_q) == rows_eff - RCW'(1));

	always_comb begin
		case (cmd.sq_sel)
			SQ_CX:   sq_m = mag(d_q);
			SQ_E0:   sq_m = mag(e_q);
			SQ_RAD:  sq_m = rad_q[MW-1:0];
			default: sq_m = '0;
		endcase
	end

	omr_squarer u_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sq_start),
		.m      (sq_m),
		.done   (sq_done),
		.square (sq_res)
	);

	assign sq_ext = $signed(TW'(sq_res));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			cx_q     <= prod_cx[PW-1:0];
			cy_q     <= prod_cy[PW-1:0];
			sx_q     <= prod_sx[PW-1:0];
			sy_q     <= prod_sy[PW-1:0];
			rad_q    <= prod_rad[PW-1:0];
			rd_row_q <= RW'(in_read_row);
			rd_col_q <= CW'(in_read_col);
			rd_oob_q <= (32'(in_read_row) >= MAX_ROWS) || (32'(in_read_col) >= MAX_COLS);
		end
		if (cmd.prep) begin
			lo_x_q <= (cx_b <<< 1) - sx_b;
			hi_x_q <= (cx_b <<< 1) + sx_b;
			lo_y_q <= (cy_b <<< 1) - sy_b;
			hi_y_q <= (cy_b <<< 1) + sy_b;
			d_q    <= -DW'(cx_q);
			e_q    <= $signed(DW'({rows_eff, 16'd0})) - DW'(cy_q);
			i_q    <= '0;
			j_q    <= '0;
			y_q    <= rows_eff;
		end
		if (cmd.sq_capture) begin
			case (cmd.sq_sel)
				SQ_CX: begin
					cx2_q <= sq_ext;
					d2_q  <= sq_ext;
				end
				// radius squared minus the first row's offset squared
				SQ_E0:   t_q <= -sq_ext;
				SQ_RAD:  t_q <= t_q + sq_ext;
				default: ;
			endcase
		end
		if (cmd.scan) begin
			if (col_last) begin
				j_q  <= '0;
				i_q  <= i_q + RW'(1);
				y_q  <= y_q - RCW'(1);
				d_q  <= -DW'(cx_q);
				d2_q <= cx2_q;
				t_q  <= t_q + (TW'(e_q) <<< 17) - STEP_SQ;
				e_q  <= e_q - STEP_D;
			end else begin
				j_q  <= j_q + CW'(1);
				d2_q <= d2_q + (TW'(d_q) <<< 17) + STEP_SQ;
				d_q  <= d_q + STEP_D;
			end
		end
		if (cmd.resp_load) begin
			if (mode_q == MODE_READ) begin
				cell_q <= (rd_oob_q || !mem_rdata[0]) ? 8'd255 : 8'd0;
			end else begin
				cell_q <= 8'd0;
			end
		end
	end

	// sweep over the whole storage, shared by the reset pass and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_comb begin
		mem_we    = cmd.clear || (cmd.scan && hit);
		mem_re    = cmd.read;
		mem_wdata = cmd.scan;
		if (cmd.clear) begin
			mem_addr = clr_addr_q;
		end else if (cmd.scan) begin
			mem_addr = {i_q, j_q};
		end else begin
			mem_addr = {rd_row_q, rd_col_q};
		end
	end

	omr_ram #(
		.WIDTH (1),
		.DEPTH (1 << AW)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		status            = '0;
		status.mode       = mode_q;
		status.empty_area = (rows_eff == '0) || (cols_eff == '0);
		status.rad_neg    = rad_q[PW-1];
		status.sq_done    = sq_done;
		status.scan_last  = col_last && row_last;
		status.clr_last   = &clr_addr_q;
	end

	assign cell_value = cell_q;

endmodule

// ===== sim/obstacle_map_checker.sv =====
`timescale 1ns / 1ps
module obstacle_map_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           failures,
	output int           outstanding
);
	import omr_pkg::*;

	// command_done sits above cell_value, as on m_tdata
	typedef struct packed {
		logic       command_done;
		logic [7:0] cell_value;
	} reply_t;

	bit          occupied [MAX_ROWS_DEF][MAX_COLS_DEF];
	logic [15:0] scale_q8;
	logic [8:0]  row_count;
	logic [8:0]  col_count;
	reply_t      replies_due [$];
	int          mismatch_count;

	function automatic void free_all_cells();
		for (int i = 0; i < MAX_ROWS_DEF; i++)
			for (int j = 0; j < MAX_COLS_DEF; j++)
				occupied[i][j] = 1'b0;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// paints the grid copy and returns the reply the command should produce
	function automatic reply_t apply_command(logic [1:0] mode_bits, logic [127:0] f);
		omr_mode_t    mode;
		longint       ppm, cx, cy, sx, sy, rad, x2, y2, dx, dy;
		int           rows, cols;
		logic [127:0] r, rr, dxw, dyw;
		reply_t       reply;
		mode = omr_mode_t'(mode_bits);
		ppm = longint'(scale_q8);
		cx = longint'($signed(f[20:0])) * ppm;
		cy = longint'($signed(f[41:21])) * ppm;
		sx = longint'($signed(f[62:42])) * ppm;
		sy = longint'($signed(f[83:63])) * ppm;
		rad = longint'($signed(f[104:84])) * ppm;
		rows = (row_count > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(row_count);
		cols = (col_count > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(col_count);
		reply.cell_value = 8'd0;
		reply.command_done = 1'b1;
		case (mode)
			MODE_CLEAR: free_all_cells();
			MODE_RECT: begin
				// both sides doubled so the half size stays exact
				for (int i = 0; i < rows; i++) begin
					y2 = longint'(rows - i) * 131072;
					if (y2 >= 2 * cy - sy && y2 <= 2 * cy + sy)
						for (int j = 0; j < cols; j++) begin
							x2 = longint'(j) * 131072;
							if (x2 >= 2 * cx - sx && x2 <= 2 * cx + sx)
								occupied[i][j] = 1'b1;
						end
				end
			end
			MODE_DISC: begin
				if (rad >= 0) begin
					r = 128'(rad);
					rr = r * r;
					for (int i = 0; i < rows; i++) begin
						dy = magnitude(longint'(rows - i) * 65536 - cy);
						dyw = 128'(dy);
						if (dyw <= r)
							for (int j = 0; j < cols; j++) begin
								dx = magnitude(longint'(j) * 65536 - cx);
								dxw = 128'(dx);
								if (dxw <= r && dxw * dxw + dyw * dyw <= rr)
									occupied[i][j] = 1'b1;
							end
					end
				end
			end
			default: reply.cell_value = occupied[f[112:105]][f[120:113]] ? 8'd0 : 8'd255;
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			free_all_cells();
			scale_q8 = PPM_RESET;
			row_count = ROWS_RESET;
			col_count = COLS_RESET;
			replies_due.delete();
			mismatch_count = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					CFG_PPM:  scale_q8 = cfg_data;
					CFG_ROWS: row_count = cfg_data[8:0];
					CFG_COLS: col_count = cfg_data[8:0];
					default: ;
				endcase
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_command(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[8:0];
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got cell_value %0d done %0b",
						$time, got.cell_value, got.command_done);
					mismatch_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.cell_value !== want.cell_value) begin
						$display("%0t: cell_value mismatch, expected %0d, got %0d",
							$time, want.cell_value, got.cell_value);
						mismatch_count++;
					end
					if (got.command_done !== want.command_done) begin
						$display("%0t: command_done mismatch, expected %0b, got %0b",
							$time, want.command_done, got.command_done);
						mismatch_count++;
					end
				end
			end
			failures <= mismatch_count;
			outstanding <= replies_due.size();
		end
	end

endmodule

// ===== sim/obstacle_map_rasterizer_test.sv =====
`timescale 1ns / 1ps
module obstacle_map_rasterizer_test;
	import omr_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_STALL = 2000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = MODE_CLEAR;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [15:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CFG_PPM;
	logic [15:0]  cfg_data = '0;

	int failures;
	int outstanding;
	int send_idle_pct = 38;
	int recv_idle_pct = 86;
	int stall_requests = 0;
	int stalls_served = 0;
	int stall_left = 0;
	int commands_sent = 0;
	int cycle_count = 0;
	int cur_ppm = PPM_RESET;
	int cur_rows = ROWS_RESET;
	int cur_cols = COLS_RESET;

	obstacle_map_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	obstacle_map_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .outstanding(outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: random back-pressure, or a long hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_requests != stalls_served) begin
			m_tready <= 1'b0;
			stall_left <= LONG_STALL;
			stalls_served <= stalls_served + 1;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// pixel position in 1/256 px to 1/256 m at the current scale, clamped to the field
	function automatic logic [20:0] units_of(int pixel_q8);
		longint v;
		if (cur_ppm == 0)
			return 21'($urandom);
		v = (longint'(pixel_q8) * 256) / cur_ppm;
		if (v > 1048575)
			v = 1048575;
		if (v < -1048576)
			v = -1048576;
		return 21'(v);
	endfunction

	task automatic send_command(input omr_mode_t mode, input logic [20:0] cx, cy, sx, sy, rad,
		input logic [7:0] row, col);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'd0, col, row, rad, sy, sx, cy, cx};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
		if (commands_sent == 35) begin
			send_idle_pct = 86;
			recv_idle_pct = 38;
		end else if (commands_sent == 70) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (index)
			CFG_PPM:  cur_ppm = value;
			CFG_ROWS: cur_rows = value[8:0];
			CFG_COLS: cur_cols = value[8:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input int ppm, rows, cols);
		drain();
		write_reg(CFG_PPM, 16'(ppm));
		write_reg(CFG_ROWS, 16'(rows));
		write_reg(CFG_COLS, 16'(cols));
	endtask

	task automatic send_random_command();
		int          pick;
		int          span_x;
		int          span_y;
		logic [20:0] cx, cy, sx, sy, rad;
		logic [7:0]  row, col;
		omr_mode_t   mode;
		span_x = (cur_cols > 256) ? 256 : ((cur_cols < 1) ? 1 : cur_cols);
		span_y = (cur_rows > 256) ? 256 : ((cur_rows < 1) ? 1 : cur_rows);
		cx = units_of($urandom_range(0, (span_x + 8) * 256) - 1024);
		cy = units_of($urandom_range(0, (span_y + 8) * 256) - 1024);
		sx = units_of($urandom_range(0, span_x * 256));
		sy = units_of($urandom_range(0, span_y * 256));
		rad = units_of($urandom_range(0, 6 * 256));
		if ($urandom_range(9) == 0)
			sx = 21'(-int'($urandom_range(1, 4000)));
		if ($urandom_range(9) == 0)
			sy = 21'(-int'($urandom_range(1, 4000)));
		if ($urandom_range(9) == 0)
			rad = 21'(-int'($urandom_range(1, 4000)));
		// raw noise over every field bit
		if ($urandom_range(7) == 0) begin
			cx = 21'($urandom);
			cy = 21'($urandom);
			sx = 21'($urandom);
			sy = 21'($urandom);
			rad = 21'($urandom);
		end
		if ($urandom_range(3) != 0) begin
			row = 8'($urandom_range(0, span_y - 1));
			col = 8'($urandom_range(0, span_x - 1));
		end else begin
			row = 8'($urandom_range(255));
			col = 8'($urandom_range(255));
		end
		pick = $urandom_range(99);
		if (pick < 2)
			mode = MODE_CLEAR;
		else if (pick < 32)
			mode = MODE_RECT;
		else if (pick < 57)
			mode = MODE_DISC;
		else
			mode = MODE_READ;
		send_command(mode, cx, cy, sx, sy, rad, row, col);
	endtask

	initial begin
		int scale;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// full default grid: a shape of each kind, read back, then clear all storage
		send_command(MODE_RECT, units_of(100 * 256), units_of(100 * 256), units_of(6 * 256),
			units_of(4 * 256), '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd156, 8'd100);
		send_command(MODE_DISC, units_of(50 * 256), units_of(200 * 256), '0, '0,
			units_of(10 * 256), 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd56, 8'd50);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd255, 8'd255);
		send_command(MODE_CLEAR, '0, '0, '0, '0, '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd156, 8'd100);

		set_grid(5120, 16, 20);
		send_command(MODE_RECT, units_of(10 * 256), units_of(8 * 256), units_of(6 * 256),
			units_of(4 * 256), '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd8, 8'd10);
		// negative width or height paints nothing
		send_command(MODE_RECT, units_of(3 * 256), units_of(3 * 256), 21'h1FFFFF,
			units_of(4 * 256), '0, 8'd0, 8'd0);
		send_command(MODE_RECT, units_of(3 * 256), units_of(3 * 256), units_of(4 * 256),
			21'h100000, '0, 8'd0, 8'd0);
		send_command(MODE_DISC, units_of(3 * 256), units_of(3 * 256), '0, '0, 21'h1FFFFF,
			8'd0, 8'd0);
		send_command(MODE_DISC, units_of(3 * 256), units_of(3 * 256), '0, '0, 21'h100000,
			8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd13, 8'd3);
		// zero radius and zero size exactly on a cell
		send_command(MODE_DISC, 21'd64, 21'd64, '0, '0, 21'd0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd11, 8'd5);
		send_command(MODE_RECT, 21'd192, 21'd128, 21'd0, 21'd0, '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd6, 8'd15);
		send_command(MODE_RECT, 21'h0FFFFF, 21'h100000, 21'h0FFFFF, 21'h0FFFFF, '0, 8'd0, 8'd0);
		send_command(MODE_RECT, 21'h100000, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, '0, 8'd0, 8'd0);
		send_command(MODE_DISC, 21'd0, 21'd0, '0, '0, 21'h0FFFFF, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd15, 8'd19);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd0, 8'd255);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd255, 8'd0);

		// zero scale collapses every coordinate onto the origin
		set_grid(0, 8, 40);
		send_command(MODE_RECT, 21'd300, 21'd300, 21'd1000, 21'd1000, '0, 8'd0, 8'd0);
		send_command(MODE_DISC, 21'd300, 21'd300, '0, '0, 21'd500, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd3, 8'd30);

		// row count above the storage saturates
		set_grid(65535, 300, 2);
		send_command(MODE_RECT, 21'd0, 21'd0, 21'h0FFFFF, 21'h0FFFFF, '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd255, 8'd1);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd200, 8'd2);

		set_grid(1, 0, 3);
		send_command(MODE_RECT, 21'd0, 21'd0, 21'h0FFFFF, 21'h0FFFFF, '0, 8'd0, 8'd0);
		set_grid(1, 3, 0);
		send_command(MODE_DISC, 21'd0, 21'd0, '0, '0, 21'h0FFFFF, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd2, 8'd40);

		set_grid(256, 2, 511);
		send_command(MODE_RECT, 21'd0, 21'd256, 21'h0FFFFF, 21'd0, '0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd1, 8'd255);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd0, 8'd200);

		set_grid(256, 1, 1);
		write_reg(CFG_SPARE, 16'($urandom));
		send_command(MODE_DISC, 21'd0, 21'd256, '0, '0, 21'd0, 8'd0, 8'd0);
		send_command(MODE_READ, '0, '0, '0, '0, '0, 8'd0, 8'd0);

		for (int phase = 0; phase < 4; phase++) begin
			case ($urandom_range(3))
				0: scale = 5120;
				1: scale = 256;
				2: scale = $urandom_range(1, 65535);
				default: scale = 2560;
			endcase
			set_grid(scale, $urandom_range(1, 24), $urandom_range(1, 24));
			// results held back while commands keep coming, so the input stalls
			if (phase == 1) begin
				stall_requests++;
				repeat (6) send_random_command();
			end
			for (int n = 0; n < 15; n++) begin
				if (phase == 2 && n == 7)
					drain();
				send_random_command();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== obstacle_map_rasterizer.f =====
+incdir+hdl
hdl/omr_pkg.sv
hdl/omr_ram.sv
hdl/omr_squarer.sv
hdl/omr_ctrl.sv
hdl/omr_datapath.sv
hdl/obstacle_map_rasterizer.sv
sim/obstacle_map_checker.sv
sim/obstacle_map_rasterizer_test.sv
